// File: sv/lcpnr_pkg.sv
// shared types, constants and the context merge for the repeat finder
// no dependencies; used by lcpnr_stack and the repeat finder unit
package lcpnr_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int INDEX_BITS  = 32;
  localparam int LCP_W       = 32;
  localparam int CHAR_W      = 8;
  localparam int OUT_W       = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [REG_IDX_W-1:0] REG_MIN_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_QUIET      = 1'b1;

  typedef struct packed {
    logic              defined;
    logic [CHAR_W-1:0] ch;
  } ctx_t;

  typedef struct packed {
    logic [LCP_W-1:0]      lcp;
    logic [INDEX_BITS-1:0] lb;
    ctx_t                  ctx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    STK_NOP,
    STK_CLEAR_PUSH,
    STK_POP,
    STK_PUSH,
    STK_SET_CTX
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    entry_t  entry;
  } stk_cmd_t;

  typedef struct packed {
    logic [SP_W-1:0] sp;
    entry_t          top;
  } stk_status_t;

  typedef struct packed {
    logic [OUT_W-1:0] lcp;
    logic [OUT_W-1:0] lb;
    logic [OUT_W-1:0] width;
    logic             last;
    logic             overflow;
  } result_t;

  // contexts stay defined only when both are defined and equal
  function automatic ctx_t ctx_merge(input ctx_t a, input ctx_t b);
    ctx_t r;
    r = '0;
    if (a.defined && b.defined && (a == b)) begin
      r = a;
    end
    return r;
  endfunction

endpackage

// File: sv/lcpnr_ram.sv
// generic single-clock ram, one write port and one registered read port
// read during write to the same address returns the old contents
module lcpnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lcpnr_stack.sv
// interval stack: top entry in registers, lower entries in lcpnr_ram
// the entry below the top is read ahead every cycle, with write forwarding
// depends on lcpnr_pkg and lcpnr_ram
module lcpnr_stack
  import lcpnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stk_cmd_t    cmd,
  output stk_status_t status
);

  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_next;
  logic [SP_W-1:0]   sp_m1;
  logic [SP_W-1:0]   below_idx;
  entry_t            top;
  entry_t            below;
  entry_t            fwd_data;
  logic              fwd_hit;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;

  always_comb begin
    sp_next = sp;
    case (cmd.op)
      STK_CLEAR_PUSH: sp_next = SP_W'(1);
      STK_POP:        sp_next = sp - SP_W'(1);
      STK_PUSH:       sp_next = sp + SP_W'(1);
      STK_SET_CTX:    sp_next = sp;
      STK_NOP:        sp_next = sp;
      default:        sp_next = sp;
    endcase
  end

  assign sp_m1     = sp - SP_W'(1);
  assign below_idx = sp_next - SP_W'(2);
  assign we        = (cmd.op == STK_PUSH) && (sp != '0);
  assign waddr     = sp_m1[ADDR_W-1:0];
  // prefetch the entry under the next top
  assign raddr     = below_idx[ADDR_W-1:0];
  assign below     = fwd_hit ? fwd_data : entry_t'(rdata);

  lcpnr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      fwd_hit <= 1'b0;
    end else begin
      sp      <= sp_next;
      fwd_hit <= we && (waddr == raddr);
    end
    fwd_data <= top;
    case (cmd.op)
      STK_CLEAR_PUSH: top <= cmd.entry;
      STK_PUSH:       top <= cmd.entry;
      STK_SET_CTX:    top.ctx <= cmd.entry.ctx;
      STK_POP: begin
        top.lcp <= below.lcp;
        top.lb  <= below.lb;
        top.ctx <= ctx_merge(top.ctx, below.ctx);
      end
      STK_NOP: top <= top;
      default: top <= top;
    endcase
  end

  assign status.sp  = sp;
  assign status.top = top;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == STK_PUSH) |-> (sp != SP_W'(STACK_DEPTH)))
    else $error("push on a full stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == STK_POP) |-> (sp != '0))
    else $error("pop on an empty stack");

endmodule

// File: sv/lcp_interval_nonextendible_repeat_finder_unit.sv
// Bottom-up LCP interval traversal that reports non-left-extendible repeat
// intervals. A word marked first is handled in S_IDLE alone; any other word
// also passes through S_LOOP and pops each interval it closes there, as the
// read-ahead port gives up one stack entry per cycle unless the loop stalls.
// Output back-pressure stalls the traversal only when a finished result cannot
// move on. The last result of each word carries last; a dropped push on a full
// stack gives a single result with overflow set. Open intervals are never flushed.
// depends on lcpnr_pkg, lcpnr_stack
module lcp_interval_nonextendible_repeat_finder_unit
  import lcpnr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  first,
  input  logic [LCP_W-1:0]      lcp_value,
  input  logic [CHAR_W-1:0]     left_char,
  input  logic                  left_defined,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      interval_lcp,
  output logic [OUT_W-1:0]      interval_lb,
  output logic [OUT_W-1:0]      interval_width,
  output logic                  last,
  output logic                  overflow,
  input  logic                  cfg_write,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {S_IDLE, S_LOOP} state_t;

  state_t                state;
  logic [LCP_W-1:0]      min_length;
  logic                  quiet;
  logic [LCP_W-1:0]      lcp_q;
  ctx_t                  ctx_q;
  logic [INDEX_BITS-1:0] lb_q;
  logic [INDEX_BITS-1:0] sa_index;
  ctx_t                  prev_ctx;
  result_t               pend;
  logic                  pend_valid;
  result_t               out_res;

  stk_cmd_t              cmd;
  stk_status_t           stat;
  ctx_t                  cur_ctx;
  logic                  in_accept;
  logic                  top_valid;
  logic                  pop_cond;
  logic                  eq_cond;
  logic                  full;
  logic                  ovf_cond;
  logic                  emit_cond;
  logic                  out_free;
  logic                  stall;
  logic                  advance;
  logic                  out_load;
  logic [INDEX_BITS-1:0] width_now;

  lcpnr_stack u_stack (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (stat)
  );

  assign cur_ctx.defined = left_defined;
  assign cur_ctx.ch      = left_defined ? left_char : '0;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  assign top_valid = (stat.sp != '0);
  assign pop_cond  = (state == S_LOOP) && top_valid && (stat.top.lcp > lcp_q);
  assign eq_cond   = top_valid && (stat.top.lcp == lcp_q);
  assign full      = (stat.sp == SP_W'(STACK_DEPTH));
  assign ovf_cond  = !pop_cond && !eq_cond && full;
  assign emit_cond = pop_cond && !stat.top.ctx.defined &&
                     (stat.top.lcp >= min_length) && !quiet;
  assign out_free  = !out_valid || out_ready;
  assign width_now = sa_index - stat.top.lb;

  // hold the loop only when a finished word has nowhere to go
  always_comb begin
    stall = 1'b0;
    if (state == S_LOOP) begin
      if (pop_cond) begin
        stall = emit_cond && pend_valid && !out_free;
      end else begin
        stall = (pend_valid || ovf_cond) && !out_free;
      end
    end
  end
  assign advance  = (state == S_LOOP) && !stall;
  // a word moves into the output register this cycle
  assign out_load = advance && (pop_cond ? (emit_cond && pend_valid)
                                         : (pend_valid || ovf_cond));

  always_comb begin
    cmd = '{op: STK_NOP, entry: '0};
    if (in_accept && first) begin
      cmd.op              = STK_CLEAR_PUSH;
      cmd.entry.ctx       = cur_ctx;
    end else if (advance) begin
      if (pop_cond) begin
        cmd.op            = STK_POP;
      end else if (eq_cond) begin
        cmd.op            = STK_SET_CTX;
        cmd.entry.ctx     = ctx_merge(stat.top.ctx, ctx_q);
      end else if (!full) begin
        cmd.op            = STK_PUSH;
        cmd.entry.lcp     = lcp_q;
        cmd.entry.lb      = lb_q;
        cmd.entry.ctx     = ctx_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      min_length <= '0;
      quiet      <= 1'b0;
      sa_index   <= '0;
      prev_ctx   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MIN_LENGTH: min_length <= cfg_data[LCP_W-1:0];
          REG_QUIET:      quiet      <= cfg_data[0];
          default:        quiet      <= quiet;
        endcase
      end
      if (out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            prev_ctx <= cur_ctx;
            if (first) begin
              sa_index <= INDEX_BITS'(1);
            end else begin
              lcp_q <= lcp_value;
              ctx_q <= ctx_merge(prev_ctx, cur_ctx);
              lb_q  <= sa_index - INDEX_BITS'(1);
              state <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          if (advance) begin
            if (pop_cond) begin
              lb_q  <= stat.top.lb;
              ctx_q <= ctx_merge(stat.top.ctx, ctx_q);
              if (emit_cond) begin
                if (pend_valid) begin
                  out_res   <= pend;
                  out_valid <= 1'b1;
                end
                pend.lcp      <= stat.top.lcp;
                pend.lb       <= OUT_W'(stat.top.lb);
                pend.width    <= OUT_W'(width_now);
                pend.last     <= 1'b0;
                pend.overflow <= 1'b0;
                pend_valid    <= 1'b1;
              end
            end else begin
              sa_index <= sa_index + INDEX_BITS'(1);
              state    <= S_IDLE;
              if (pend_valid) begin
                out_res    <= '{lcp: pend.lcp, lb: pend.lb, width: pend.width,
                                last: 1'b1, overflow: pend.overflow};
                out_valid  <= 1'b1;
                pend_valid <= 1'b0;
              end else if (ovf_cond) begin
                out_res   <= '{lcp: '0, lb: '0, width: '0, last: 1'b1, overflow: 1'b1};
                out_valid <= 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign interval_lcp   = out_res.lcp;
  assign interval_lb    = out_res.lb;
  assign interval_width = out_res.width;
  assign last           = out_res.last;
  assign overflow       = out_res.overflow;

  a_ovf_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> last)
    else $error("overflow word without last");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending word left behind at end of item");

  a_stall_keeps_stack: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(stat.sp))
    else $error("stack moved during a stall");

  a_ovf_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP && ovf_cond) |-> !pend_valid)
    else $error("overflow after a reported interval");

endmodule
